>>> sv/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned ModeW  = 3;
    localparam int unsigned NLanes = 3;

    typedef enum logic [ModeW-1:0] {
        MODE_MULTIPLY = 3'd0,
        MODE_SCREEN   = 3'd1,
        MODE_SUBTRACT = 3'd2,
        MODE_ADD      = 3'd3,
        MODE_OVERLAY  = 3'd4,
        MODE_RED      = 3'd5,
        MODE_GREEN    = 3'd6,
        MODE_BLUE     = 3'd7
    } t_blend_mode;

    localparam t_blend_mode ModeReset = MODE_MULTIPLY;

    typedef struct packed {
        t_blend_mode mode;
        logic        en1;
    } t_lane_ctrl;

    typedef struct packed {
        t_blend_mode mode;
        logic        en2;
    } t_merge_ctrl;

endpackage

>>> sv/rpb_lane.sv
`timescale 1ns / 1ps

module rpb_lane (
    input  logic                             i_clk,
    input  rpb_pkg::t_lane_ctrl              i_ctrl,
    input  logic [rpb_pkg::ChanW-1:0]        i_a,
    input  logic [rpb_pkg::ChanW-1:0]        i_b,
    output logic [rpb_pkg::ChanW-1:0]        o_res
);

    localparam int unsigned W  = rpb_pkg::ChanW;
    localparam int unsigned PW = 2 * W;

    logic          n_swap;
    logic [W-1:0]  n_x;
    logic [W-1:0]  n_y;
    logic [W:0]    n_diff;
    logic [W:0]    n_sum;
    logic [W-1:0]  n_sub;
    logic [W-1:0]  n_add;

    logic [PW-1:0] r_prod;
    logic          r_swap;
    logic [W-1:0]  r_sub;
    logic [W-1:0]  r_add;
    logic [W-1:0]  r_a;

    logic [PW:0]   num;
    logic [PW:0]   tmp;
    logic [W-1:0]  q;

    // stage 1: operand select, 8x8 multiply, saturating add/sub
    always_comb begin
        n_swap = (i_ctrl.mode == rpb_pkg::MODE_SCREEN) ||
                 ((i_ctrl.mode == rpb_pkg::MODE_OVERLAY) && i_b[W-1]);
        n_x    = n_swap ? ~i_a : i_a;
        n_y    = n_swap ? ~i_b : i_b;
        n_diff = {1'b0, i_a} - {1'b0, i_b};
        n_sum  = {1'b0, i_a} + {1'b0, i_b};
        n_sub  = n_diff[W] ? '0 : n_diff[W-1:0];
        n_add  = n_sum[W]  ? '1 : n_sum[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_prod <= n_x * n_y;
            r_swap <= n_swap;
            r_sub  <= n_sub;
            r_add  <= n_add;
            r_a    <= i_a;
        end
    end

    // stage 2: exact divide by 255; overlay rounding folded into 2p+127
    always_comb begin
        if (i_ctrl.mode == rpb_pkg::MODE_OVERLAY) begin
            num = {r_prod, 1'b0} + (PW+1)'(127);
        end else begin
            num = {1'b0, r_prod};
        end
        tmp = num + (PW+1)'(1) + {{W{1'b0}}, num[PW:W]};
        q   = tmp[PW-1:W];
        case (i_ctrl.mode)
            rpb_pkg::MODE_MULTIPLY: o_res = q;
            rpb_pkg::MODE_SCREEN:   o_res = ~q;
            rpb_pkg::MODE_SUBTRACT: o_res = r_sub;
            rpb_pkg::MODE_ADD:      o_res = r_add;
            rpb_pkg::MODE_OVERLAY:  o_res = r_swap ? ~q : q;
            default:                o_res = r_a;
        endcase
    end

endmodule

>>> sv/rpb_merge.sv
`timescale 1ns / 1ps

module rpb_merge (
    input  logic                                          i_clk,
    input  rpb_pkg::t_merge_ctrl                          i_ctrl,
    input  logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] i_lane,
    input  logic                                          i_last,
    output logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] o_pix,
    output logic                                          o_last
);

    logic [rpb_pkg::NLanes-1:0]                    keep;
    logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] n_pix;
    logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] r_pix;
    logic                                          r_last;

    always_comb begin
        case (i_ctrl.mode)
            rpb_pkg::MODE_RED:   keep = 3'b001;
            rpb_pkg::MODE_GREEN: keep = 3'b010;
            rpb_pkg::MODE_BLUE:  keep = 3'b100;
            default:             keep = 3'b111;
        endcase
        for (int i = 0; i < rpb_pkg::NLanes; i++) begin
            n_pix[i] = keep[i] ? i_lane[i] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_pix  <= n_pix;
            r_last <= i_last;
        end
    end

    assign o_pix  = r_pix;
    assign o_last = r_last;

endmodule

>>> sv/rgb_pixel_blend_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Carries
// pixel in  in         i_valid / o_ready           top and bottom RGB, end marker
// pixel out out        o_valid / i_ready           blended RGB, last marker
// config    in         i_cfg_valid / o_cfg_ready   blend mode
//
// Two-stage pipeline, one pixel per clock while i_ready holds: stage 1 is the
// 8x8 multiply in each of the three lanes, stage 2 the divide-by-255 and the
// channel merge register. Each stage advances on its own, so a new request
// is taken while a result waits, as long as stage 1 is empty.
// Synchronous active-low reset clears the valid bits and the mode (multiply).

module rgb_pixel_blend_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [rpb_pkg::ChanW-1:0]  i_top_red,
    input  logic [rpb_pkg::ChanW-1:0]  i_top_green,
    input  logic [rpb_pkg::ChanW-1:0]  i_top_blue,
    input  logic [rpb_pkg::ChanW-1:0]  i_bottom_red,
    input  logic [rpb_pkg::ChanW-1:0]  i_bottom_green,
    input  logic [rpb_pkg::ChanW-1:0]  i_bottom_blue,
    input  logic                       i_end_of_image,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rpb_pkg::ChanW-1:0]  o_out_red,
    output logic [rpb_pkg::ChanW-1:0]  o_out_green,
    output logic [rpb_pkg::ChanW-1:0]  o_out_blue,
    output logic                       o_out_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [rpb_pkg::ModeW-1:0]  i_cfg_blend_mode
);

    rpb_pkg::t_blend_mode r_mode;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_last1;
    logic                 en1;
    logic                 en2;

    rpb_pkg::t_lane_ctrl  lane_ctrl;
    rpb_pkg::t_merge_ctrl merge_ctrl;

    logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] top;
    logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] bot;
    logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] lane_res;
    logic [rpb_pkg::NLanes-1:0][rpb_pkg::ChanW-1:0] pix;

    assign en2 = !r_v2 || i_ready;
    assign en1 = !r_v1 || en2;

    assign o_ready     = en1;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_v2;

    assign lane_ctrl.mode  = r_mode;
    assign lane_ctrl.en1   = en1;
    assign merge_ctrl.mode = r_mode;
    assign merge_ctrl.en2  = en2;

    assign top = {i_top_blue, i_top_green, i_top_red};
    assign bot = {i_bottom_blue, i_bottom_green, i_bottom_red};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rpb_pkg::ModeReset;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= rpb_pkg::t_blend_mode'(i_cfg_blend_mode);
            end
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_last1 <= i_end_of_image;
        end
    end

    for (genvar g = 0; g < rpb_pkg::NLanes; g++) begin : g_lane
        rpb_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (lane_ctrl),
            .i_a    (top[g]),
            .i_b    (bot[g]),
            .o_res  (lane_res[g])
        );
    end

    rpb_merge u_merge (
        .i_clk  (i_clk),
        .i_ctrl (merge_ctrl),
        .i_lane (lane_res),
        .i_last (r_last1),
        .o_pix  (pix),
        .o_last (o_out_last)
    );

    assign o_out_red   = pix[0];
    assign o_out_green = pix[1];
    assign o_out_blue  = pix[2];

endmodule
